FILE: design/assert_macros.svh
// Assertion macros for the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under synchronous active-low reset.
`define GBTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication under synchronous active-low reset.
`define GBTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: design/gbts_pkg.sv
// Types, constants and item layouts of the gap buffer text store.
package gbts_pkg;

    localparam int CAPACITY    = 4096;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int LEN_W       = $clog2(CAPACITY + 1);
    localparam int UNIT_W      = 16;
    localparam int OP_W        = 2;
    localparam int ST_W        = 2;
    localparam int S_FIELDS_W  = OP_W + LEN_W + UNIT_W + LEN_W;
    localparam int S_TDATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W  = UNIT_W + LEN_W + ST_W;
    localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SLIDE,
        S_MOVE_WR,
        S_RD_ISSUE,
        S_RD_CAPT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [S_TDATA_W-S_FIELDS_W-1:0] pad;
        logic [LEN_W-1:0]                count;
        logic [UNIT_W-1:0]               unit;
        logic [LEN_W-1:0]                offset;
        t_op                             operation;
    } t_s_item;

    typedef struct packed {
        logic [M_TDATA_W-M_FIELDS_W-1:0] pad;
        t_status                         status;
        logic [LEN_W-1:0]                content_length;
        logic [UNIT_W-1:0]               read_unit;
    } t_m_item;

    typedef struct packed {
        logic accept;
        logic check;
        logic clear;
        logic mv_rd;
        logic mv_wr;
        logic finish;
        logic rd_issue;
        logic rd_capture;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        t_op  op;
        logic chk_ok;
        logic count_zero;
        logic at_target;
        logic out_free;
    } t_dp_stat;

endpackage

FILE: design/gap_buffer_text_store.sv
// Top level of the gap buffer text store: controller plus datapath.
// One transaction at a time. A clear, a rejected item or a removal of zero units goes
// from the check straight to the result load; a read issues a store read and captures it;
// an insert or a removal first slides the gap to its offset, one unit per read and write step.
// The next transaction is accepted in the cycle after the result loads.
// Reset clears the gap to cover the whole store and empties the result register.
module gap_buffer_text_store (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // operation[1:0], offset[14:2], unit[30:15], count[43:31], zero pad
    input  logic [gbts_pkg::S_TDATA_W-1:0] i_s_tdata,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // read_unit[15:0], content_length[28:16], status[30:29], zero pad
    output logic [gbts_pkg::M_TDATA_W-1:0] o_m_tdata
);
    import gbts_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;
    t_s_item  s_item;
    t_m_item  m_item;

    assign s_item    = t_s_item'(i_s_tdata);
    assign o_m_tdata = m_item;

    gbts_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_tvalid),
        .i_stat    (stat),
        .o_cmd     (cmd),
        .o_s_ready (o_s_tready)
    );

    gbts_dpath u_dpath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (s_item),
        .i_cmd     (cmd),
        .i_m_ready (i_m_tready),
        .o_stat    (stat),
        .o_m_valid (o_m_tvalid),
        .o_m_item  (m_item)
    );

endmodule

FILE: design/gbts_ctrl.sv
// Controller state machine sequencing checks, gap slides, reads and result loads.
module gbts_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_valid,
    input  gbts_pkg::t_dp_stat i_stat,
    output gbts_pkg::t_dp_cmd  o_cmd,
    output logic              o_s_ready
);
    import gbts_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_stat.chk_ok) begin
                    n_state = S_DONE;
                end else begin
                    case (i_stat.op)
                        OP_INSERT: n_state = S_SLIDE;
                        OP_REMOVE: n_state = i_stat.count_zero ? S_DONE : S_SLIDE;
                        OP_READ:   n_state = S_RD_ISSUE;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_SLIDE:    n_state = i_stat.at_target ? S_DONE : S_MOVE_WR;
            S_MOVE_WR:  n_state = S_SLIDE;
            S_RD_ISSUE: n_state = S_RD_CAPT;
            S_RD_CAPT:  n_state = S_DONE;
            S_DONE: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd     = '0;
        o_s_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_ready    = 1'b1;
                o_cmd.accept = i_s_valid;
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                o_cmd.clear = i_stat.chk_ok && (i_stat.op == OP_CLEAR);
            end
            S_SLIDE: begin
                o_cmd.finish = i_stat.at_target;
                o_cmd.mv_rd  = !i_stat.at_target;
            end
            S_MOVE_WR:  o_cmd.mv_wr      = 1'b1;
            S_RD_ISSUE: o_cmd.rd_issue   = 1'b1;
            S_RD_CAPT:  o_cmd.rd_capture = 1'b1;
            S_DONE:     o_cmd.load_out   = i_stat.out_free;
            default:    o_cmd            = '0;
        endcase
    end

endmodule

FILE: design/gbts_dpath.sv
// Datapath: unit store, gap registers, bounds checks and the result register.
module gbts_dpath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gbts_pkg::t_s_item  i_item,
    input  gbts_pkg::t_dp_cmd  i_cmd,
    input  logic               i_m_ready,
    output gbts_pkg::t_dp_stat o_stat,
    output logic               o_m_valid,
    output gbts_pkg::t_m_item  o_m_item
);
    import gbts_pkg::*;

    logic [UNIT_W-1:0] mem [CAPACITY];

    t_op               r_op;
    logic [LEN_W-1:0]  r_offset;
    logic [UNIT_W-1:0] r_unit;
    logic [LEN_W-1:0]  r_count;
    t_status           r_status;
    logic [UNIT_W-1:0] r_rd_unit;
    logic [LEN_W-1:0]  r_gs;
    logic [LEN_W-1:0]  r_gl;
    logic [UNIT_W-1:0] r_mem_q;
    logic              r_out_valid;
    t_m_item           r_out_item;

    logic [LEN_W-1:0]  len;
    logic [LEN_W:0]    rm_end;
    t_status           chk_status;
    logic              down;
    logic [LEN_W-1:0]  phys;
    logic [LEN_W-1:0]  src;
    logic [LEN_W-1:0]  dst;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [UNIT_W-1:0] wr_data;

    assign len    = LEN_W'(CAPACITY) - r_gl;
    assign rm_end = {1'b0, r_offset} + {1'b0, r_count};

    always_comb begin
        chk_status = ST_DONE;
        case (r_op)
            OP_INSERT: begin
                if (r_offset > len) begin
                    chk_status = ST_RANGE;
                end else if (r_gl == '0) begin
                    chk_status = ST_FULL;
                end
            end
            OP_REMOVE: begin
                if (rm_end > {1'b0, len}) begin
                    chk_status = ST_RANGE;
                end
            end
            OP_READ: begin
                if (r_offset >= len) begin
                    chk_status = ST_RANGE;
                end
            end
            default: chk_status = ST_DONE;
        endcase
    end

    assign down = r_offset < r_gs;
    assign phys = down ? r_offset : r_offset + r_gl;
    assign src  = down ? r_gs - LEN_W'(1) : r_gs + r_gl;
    assign dst  = down ? r_gs - LEN_W'(1) + r_gl : r_gs;

    assign rd_en   = i_cmd.mv_rd || i_cmd.rd_issue;
    assign rd_addr = i_cmd.rd_issue ? phys[ADDR_W-1:0] : src[ADDR_W-1:0];
    assign wr_en   = i_cmd.mv_wr || (i_cmd.finish && (r_op == OP_INSERT));
    assign wr_addr = i_cmd.mv_wr ? dst[ADDR_W-1:0] : r_gs[ADDR_W-1:0];
    assign wr_data = i_cmd.mv_wr ? r_mem_q : r_unit;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_mem_q <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op      <= i_item.operation;
            r_offset  <= i_item.offset;
            r_unit    <= i_item.unit;
            r_count   <= i_item.count;
            r_rd_unit <= '0;
        end else if (i_cmd.rd_capture) begin
            r_rd_unit <= r_mem_q;
        end
        if (i_cmd.check) begin
            r_status <= chk_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gs <= '0;
            r_gl <= LEN_W'(CAPACITY);
        end else if (i_cmd.clear) begin
            r_gs <= '0;
            r_gl <= LEN_W'(CAPACITY);
        end else if (i_cmd.mv_wr) begin
            r_gs <= down ? r_gs - LEN_W'(1) : r_gs + LEN_W'(1);
        end else if (i_cmd.finish) begin
            if (r_op == OP_INSERT) begin
                r_gs <= r_gs + LEN_W'(1);
                r_gl <= r_gl - LEN_W'(1);
            end else begin
                r_gl <= r_gl + r_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_item.pad            <= '0;
            r_out_item.status         <= r_status;
            r_out_item.content_length <= len;
            r_out_item.read_unit      <= r_rd_unit;
        end
    end

    assign o_stat.op         = r_op;
    assign o_stat.chk_ok     = (chk_status == ST_DONE);
    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.at_target  = (r_offset == r_gs);
    assign o_stat.out_free   = !r_out_valid || i_m_ready;

    assign o_m_valid = r_out_valid;
    assign o_m_item  = r_out_item;

endmodule

FILE: design/gbts_checker.sv
// Port-level checker for the gap buffer text store, bound to the top level.
`include "assert_macros.svh"

module gbts_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_tvalid,
    input logic                           o_s_tready,
    input logic [gbts_pkg::S_TDATA_W-1:0] i_s_tdata,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [gbts_pkg::M_TDATA_W-1:0] o_m_tdata
);
    import gbts_pkg::*;

    t_m_item m_item;
    logic    s_xact;
    logic    m_stall;

    assign m_item  = t_m_item'(o_m_tdata);
    assign s_xact  = i_s_tvalid && o_s_tready;
    assign m_stall = o_m_tvalid && !i_m_tready;

    `GBTS_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, s_xact, !o_s_tready)
    `GBTS_ASSERT_IMP(a_read_only_on_done, i_clk, i_rst_n, o_m_tvalid && (m_item.read_unit != '0), m_item.status == ST_DONE)
    `GBTS_ASSERT_NXT(a_valid_holds, i_clk, i_rst_n, m_stall, o_m_tvalid)
    `GBTS_ASSERT_NXT(a_data_holds, i_clk, i_rst_n, m_stall, $stable(o_m_tdata))

endmodule

bind gap_buffer_text_store gbts_checker u_gbts_checker (.*);

FILE: test/tb_gap_buffer_text_store.sv
// Testbench of the gap buffer text store: directed and random stream stimulus checked against a predictor.
import gbts_pkg::*;

class text_store_scoreboard;
    logic [UNIT_W-1:0] text[$];
    int                gap_pos     = 0;
    t_m_item           pending_results[$];
    int                mismatches  = 0;
    int                checked     = 0;
    int                full_seen   = 0;
    int                range_seen  = 0;
    int                op_seen[4]  = '{0, 0, 0, 0};

    function t_m_item apply_edit(t_s_item it);
        t_m_item r;
        int      len;
        int      off;
        int      cnt;
        r        = '0;
        r.status = ST_DONE;
        len      = text.size();
        off      = it.offset;
        cnt      = it.count;
        case (it.operation)
            OP_INSERT: begin
                if (off > len) begin
                    r.status = ST_RANGE;
                end else if (len == CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    if (off == len) text.push_back(it.unit);
                    else text.insert(off, it.unit);
                    gap_pos = off + 1;
                end
            end
            OP_REMOVE: begin
                if (off + cnt > len) begin
                    r.status = ST_RANGE;
                end else if (cnt != 0) begin
                    repeat (cnt) text.delete(off);
                    gap_pos = off;
                end
            end
            OP_READ: begin
                if (off >= len) r.status = ST_RANGE;
                else r.read_unit = text[off];
            end
            default: begin
                text.delete();
                gap_pos = 0;
            end
        endcase
        r.content_length = LEN_W'(text.size());
        return r;
    endfunction

    function void note_request(t_s_item it);
        t_m_item r;
        r = apply_edit(it);
        op_seen[int'(it.operation)]++;
        if (r.status == ST_FULL) full_seen++;
        if (r.status == ST_RANGE) range_seen++;
        pending_results.push_back(r);
    endfunction

    function void check_response(t_m_item got);
        t_m_item want;
        checked++;
        if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result %h with no transaction pending", got);
            return;
        end
        want = pending_results.pop_front();
        if (got.read_unit !== want.read_unit || got.content_length !== want.content_length
                || got.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d: want unit %h len %0d st %0d, got unit %h len %0d st %0d",
                         checked, want.read_unit, want.content_length, want.status,
                         got.read_unit, got.content_length, got.status);
        end
    endfunction
endclass

module tb_gap_buffer_text_store;

    localparam int IDLE_LIMIT   = 40000;
    localparam int SETTLE_TICKS = 20;
    localparam int HOLDOFF      = 400;
    localparam int FILL_UNITS   = 64;

    logic                 clk;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    text_store_scoreboard sb = new();

    gap_buffer_text_store u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk) begin
        if (rst_n && m_tvalid === 1'b1 && m_tready)
            sb.check_response(t_m_item'(m_tdata));
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", quiet_cycles);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic send_item(input t_s_item it);
        if ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < src_idle_pct) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= it;
        @(posedge clk);
        while (s_tready !== 1'b1) @(posedge clk);
        sb.note_request(it);
    endtask

    task automatic send_op(input t_op op, input int off, input int unit, input int cnt);
        t_s_item it;
        it           = '0;
        it.operation = op;
        it.offset    = LEN_W'(off);
        it.unit      = UNIT_W'(unit);
        it.count     = LEN_W'(cnt);
        send_item(it);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge clk);
    endtask

    function automatic t_s_item local_edit();
        t_s_item it;
        int      len;
        int      pick;
        int      lo;
        int      hi;
        int      off;
        int      cnt;
        it      = '0;
        it.unit = UNIT_W'($urandom);
        len     = sb.text.size();
        pick    = $urandom_range(99);
        lo      = (sb.gap_pos > 3) ? sb.gap_pos - 3 : 0;
        hi      = (sb.gap_pos + 3 < len) ? sb.gap_pos + 3 : len;
        off     = $urandom_range(hi, lo);
        cnt     = $urandom_range(4, 0);
        if (pick >= 88 && pick < 92) begin
            off = $urandom_range(len, 0);
            cnt = 1;
        end
        if (off + cnt > len && $urandom_range(3) != 0)
            cnt = len - off;
        if (pick < 40 || (pick >= 88 && pick < 90)) begin
            it.operation = OP_INSERT;
            it.offset    = LEN_W'(off);
        end else if (pick < 60 || (pick >= 90 && pick < 92)) begin
            it.operation = OP_REMOVE;
            it.offset    = LEN_W'(off);
            it.count     = LEN_W'(cnt);
        end else if (pick < 86) begin
            it.operation = OP_READ;
            it.offset    = (len > 0) ? LEN_W'($urandom_range(len - 1, 0)) : '0;
        end else if (pick < 88) begin
            it.operation = OP_CLEAR;
            it.offset    = LEN_W'($urandom);
        end else begin
            it.operation = t_op'($urandom_range(3, 0));
            it.offset    = LEN_W'($urandom);
            it.count     = LEN_W'($urandom);
        end
        return it;
    endfunction

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        send_op(OP_READ,   0,    0,       0);
        send_op(OP_REMOVE, 0,    0,       0);
        send_op(OP_REMOVE, 0,    0,       1);
        send_op(OP_INSERT, 1,    16'h1111, 0);
        send_op(OP_INSERT, 0,    16'h0000, 0);
        send_op(OP_INSERT, 1,    16'hFFFF, 0);
        send_op(OP_INSERT, 0,    16'h8000, 0);
        send_op(OP_INSERT, 3,    16'h5A5A, 0);
        send_op(OP_READ,   0,    0,       0);
        send_op(OP_READ,   3,    0,       0);
        send_op(OP_READ,   4,    0,       0);
        send_op(OP_READ,   8191, 16'hFFFF, 8191);
        send_op(OP_REMOVE, 2,    0,       0);
        send_op(OP_REMOVE, 1,    0,       2);
        send_op(OP_REMOVE, 8191, 0,       8191);
        send_op(OP_INSERT, 8191, 16'hFFFF, 0);
        send_op(OP_REMOVE, 0,    0,       4097);
        send_op(OP_READ,   1,    0,       0);
        send_op(OP_CLEAR,  8191, 16'hFFFF, 8191);
        send_op(OP_READ,   0,    0,       0);
        send_op(OP_INSERT, 0,    16'h1234, 0);

        for (int p = 0; p < 4; p++) begin
            case (p)
                0:       begin src_idle_pct = 0;  snk_stall_pct <= 0;  end
                1:       begin src_idle_pct = 49; snk_stall_pct <= 0;  end
                2:       begin src_idle_pct = 0;  snk_stall_pct <= 49; end
                default: begin src_idle_pct = 6;  snk_stall_pct <= 6;  end
            endcase
            for (int n = 0; n < 250; n++) begin
                if (p == 0 && n == 120) hold_left <= HOLDOFF;
                send_item(local_edit());
            end
            if (p == 1) drain();
        end

        src_idle_pct = 0;
        snk_stall_pct <= 0;
        send_op(OP_CLEAR, 0, 0, 0);
        repeat (FILL_UNITS) send_op(OP_INSERT, sb.gap_pos, $urandom_range(65535, 0), 0);
        send_op(OP_INSERT, FILL_UNITS + 1, 16'hABCD, 0);
        send_op(OP_INSERT, 0,              16'hABCD, 0);
        send_op(OP_READ,   0,              0,        0);
        send_op(OP_READ,   FILL_UNITS,     0,        0);
        send_op(OP_READ,   FILL_UNITS + 1, 0,        0);
        repeat (16) send_op(OP_READ, $urandom_range(FILL_UNITS, 0), 0, 0);
        send_op(OP_REMOVE, 1,              0,        FILL_UNITS + 1);
        send_op(OP_REMOVE, 0,              0,        1);
        send_op(OP_INSERT, 0,              16'h7E7E, 0);
        send_op(OP_REMOVE, FILL_UNITS - 1, 0,        1);
        send_op(OP_READ,   FILL_UNITS - 1, 0,        0);
        send_op(OP_INSERT, FILL_UNITS,     16'h0101, 0);
        send_op(OP_REMOVE, 0,              0,        FILL_UNITS + 1);
        send_op(OP_READ,   0,              0,        0);

        drain();
        repeat (SETTLE_TICKS) @(posedge clk);

        $display("covered %0d inserts, %0d removals, %0d reads, %0d clears, long gap slides",
                 sb.op_seen[OP_INSERT], sb.op_seen[OP_REMOVE], sb.op_seen[OP_READ],
                 sb.op_seen[OP_CLEAR]);
        $display("%0d results checked, %0d out-of-range and %0d full rejects, %0d mismatches",
                 sb.checked, sb.range_seen, sb.full_seen, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
